### rtl/asg_pkg.sv
// Types and constants shared by the arbitrage signal generator.
package asg_pkg;

	typedef struct packed {
		logic [31:0]        price;
		logic signed [31:0] spread;
		logic [31:0]        liquidity_sample;
	} tick_t;

	typedef struct packed {
		logic [1:0]  action;
		logic [31:0] trade_size;
		logic [31:0] trade_price;
	} signal_t;

	localparam logic [1:0] ACT_HOLD = 2'd0;
	localparam logic [1:0] ACT_BUY  = 2'd1;
	localparam logic [1:0] ACT_SELL = 2'd2;

	localparam logic [2:0] REG_TRANSACTION_COST  = 3'd0;
	localparam logic [2:0] REG_FILL_LATENCY      = 3'd1;
	localparam logic [2:0] REG_SLIPPAGE_FACTOR   = 3'd2;
	localparam logic [2:0] REG_MINIMUM_LIQUIDITY = 3'd3;
	localparam logic [2:0] REG_RISK_MULTIPLIER   = 3'd4;
	localparam logic [2:0] REG_MAX_POSITION      = 3'd5;
	localparam logic [2:0] REG_TREND_PERIOD      = 3'd6;

	localparam int ACC_W = 128;
	localparam int ACC_N = 9;

	localparam logic [3:0] ACC_SQS  = 4'd0;
	localparam logic [3:0] ACC_VAR  = 4'd1;
	localparam logic [3:0] ACC_DSQ  = 4'd2;
	localparam logic [3:0] ACC_DK   = 4'd3;
	localparam logic [3:0] ACC_RHS  = 4'd4;
	localparam logic [3:0] ACC_LIQ  = 4'd5;
	localparam logic [3:0] ACC_SIZE = 4'd6;
	localparam logic [3:0] ACC_TA   = 4'd7;
	localparam logic [3:0] ACC_TB   = 4'd8;

	typedef struct packed {
		logic [31:0] a;
		logic [31:0] b;
		logic [3:0]  dest;
		logic [1:0]  sh;
		logic        sub;
	} mop_t;

	localparam int NOPS = 20;

endpackage

### rtl/arbitrage_signal_generator.sv
// Arbitrage signal generator: windowed statistics and trade decision on one shared multiplier.
//
// Channel  | Handshake                  | Payload
// tick     | tick_valid / tick_stall    | tick_data (price, difference, liquidity)
// sig      | sig_valid / sig_stall      | sig_data (action, size, entry price)
// cfg      | cfg_valid / cfg_ready      | cfg_index, cfg_data
//
// A request runs the update step, the slope fit (trend length two or more, fit window filled),
// the multiply sequence on the single 32x32 multiplier and the decision step; the one-entry
// price memory read port paces the fit. The tick channel stalls while a request is in work.
// A finished result waits in the output register while the next request is taken.
// Reset is asynchronous and clears fills, running sums and control state.
module arbitrage_signal_generator #(
	parameter int PRICE_WINDOW_MAX = 64,
	parameter int DEV_WINDOW       = 30,
	parameter int LIQ_WINDOW       = 5
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            tick_valid,
	output logic            tick_stall,
	input  asg_pkg::tick_t  tick_data,
	output logic            sig_valid,
	input  logic            sig_stall,
	output asg_pkg::signal_t sig_data,
	input  logic            cfg_valid,
	output logic            cfg_ready,
	input  logic [2:0]      cfg_index,
	input  logic [31:0]     cfg_data
);
	import asg_pkg::*;

	localparam int PFW = $clog2(PRICE_WINDOW_MAX + 1);
	localparam int PAW = $clog2(PRICE_WINDOW_MAX);
	localparam int DW  = $clog2(DEV_WINDOW + 1);
	localparam int DAW = $clog2(DEV_WINDOW);
	localparam int LFW = $clog2(LIQ_WINDOW + 1);
	localparam int LW  = 32 + LFW;
	localparam int SW  = 33 + DW;
	localparam int QW  = 32 + PFW;
	localparam int WW  = 32 + 2 * PFW;
	localparam int CW  = (PFW > 7) ? PFW : 7;
	localparam logic [31:0] DEV_K = 32'(10000 * DEV_WINDOW * DEV_WINDOW);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_UPD  = 3'd1;
	localparam logic [2:0] ST_TRD  = 3'd2;
	localparam logic [2:0] ST_MUL  = 3'd3;
	localparam logic [2:0] ST_DEC  = 3'd4;

	logic [2:0]  state_q;
	logic [6:0]  cnt_q;
	tick_t       tick_q;
	logic [31:0] tc_q, fl_q, sf_q, ml_q, rm_q, mp_q;
	logic [6:0]  tp_q;

	logic [31:0] price_mem [PRICE_WINDOW_MAX];
	logic [31:0] diff_mem [DEV_WINDOW];
	logic [31:0] prd_q, drd_q;
	logic [PAW-1:0] pn_q, rp_q, pn_next;
	logic [DAW-1:0] dw_q;
	logic [PFW-1:0] pfill_q;
	logic [DW-1:0]  dfill_q;
	logic [LFW-1:0] lfill_q;
	logic [31:0]    liq_q [LIQ_WINDOW];
	logic [LW-1:0]  lsum_q;
	logic signed [SW-1:0] dsum_q;
	logic [31:0]    mo_q;
	logic [12:0]    sx_q;
	logic           tv_q;
	logic [QW-1:0]  psum_q;
	logic [WW-1:0]  wsum_q;
	logic [31:0]    first_q;
	logic [ACC_W-1:0] acc_q [ACC_N];
	logic [63:0]    prod_s1;
	mop_t           op_s1;
	logic           mv_s1;
	logic           sig_valid_q;
	signal_t        sig_q;

	logic [31:0]    mn;
	logic [63:0]    smag;
	logic [63:0]    wz, pz;
	logic [95:0]    s2z;
	mop_t           op;
	logic [ACC_W-1:0] shifted, acc_sum;
	logic [QW-1:0]  q_next;
	logic           load;
	logic           dfull;
	logic           profitable, beyond, tpos, tneg;
	logic [ACC_W-1:0] var_eff;
	logic [31:0]    size;
	logic signed [SW-1:0] d_ext;

	assign cfg_ready  = 1'b1;
	assign tick_stall = (state_q != ST_IDLE);
	assign sig_valid  = sig_valid_q;
	assign sig_data   = sig_q;

	assign pn_next = (pn_q == PAW'(PRICE_WINDOW_MAX - 1)) ? '0 : pn_q + 1'b1;
	assign mn      = tick_q.spread[31] ? (~tick_q.spread + 32'd1)
		: tick_q.spread;
	assign d_ext   = SW'(tick_q.spread);
	assign smag    = 64'(dsum_q[SW-1] ? -dsum_q : dsum_q);
	assign wz      = 64'(wsum_q);
	assign pz      = 64'(psum_q);
	assign s2z     = acc_q[ACC_SQS][95:0];
	assign dfull   = (dfill_q == DW'(DEV_WINDOW));

	always_comb begin
		op = '0;
		unique case (cnt_q[4:0])
			5'd0:  op = '{mn, mn, ACC_SQS, 2'd0, 1'b0};
			5'd1:  op = '{mo_q, mo_q, ACC_SQS, 2'd0, 1'b1};
			5'd2:  op = '{mn, mn, ACC_DSQ, 2'd0, 1'b0};
			5'd3:  op = '{fl_q, sf_q, ACC_RHS, 2'd0, 1'b0};
			5'd4:  op = '{tc_q, 32'h10000, ACC_RHS, 2'd0, 1'b0};
			5'd5:  op = '{ml_q, 32'(lfill_q), ACC_LIQ, 2'd0, 1'b0};
			5'd6:  op = '{mn, rm_q, ACC_SIZE, 2'd0, 1'b0};
			5'd7:  op = '{s2z[31:0], 32'(DEV_WINDOW), ACC_VAR, 2'd0, 1'b0};
			5'd8:  op = '{s2z[63:32], 32'(DEV_WINDOW), ACC_VAR, 2'd1, 1'b0};
			5'd9:  op = '{s2z[95:64], 32'(DEV_WINDOW), ACC_VAR, 2'd2, 1'b0};
			5'd10: op = '{smag[31:0], smag[31:0], ACC_VAR, 2'd0, 1'b1};
			5'd11: op = '{smag[31:0], smag[63:32], ACC_VAR, 2'd1, 1'b1};
			5'd12: op = '{smag[63:32], smag[31:0], ACC_VAR, 2'd1, 1'b1};
			5'd13: op = '{smag[63:32], smag[63:32], ACC_VAR, 2'd2, 1'b1};
			5'd14: op = '{acc_q[ACC_DSQ][31:0], DEV_K, ACC_DK, 2'd0, 1'b0};
			5'd15: op = '{acc_q[ACC_DSQ][63:32], DEV_K, ACC_DK, 2'd1, 1'b0};
			5'd16: op = '{wz[31:0], 32'(tp_q), ACC_TA, 2'd0, 1'b0};
			5'd17: op = '{wz[63:32], 32'(tp_q), ACC_TA, 2'd1, 1'b0};
			5'd18: op = '{pz[31:0], 32'(sx_q), ACC_TB, 2'd0, 1'b0};
			5'd19: op = '{pz[63:32], 32'(sx_q), ACC_TB, 2'd1, 1'b0};
			default: op = '0;
		endcase
	end

	assign shifted = ACC_W'(prod_s1) << (7'd32 * 7'(op_s1.sh));
	assign acc_sum = op_s1.sub ? acc_q[op_s1.dest] - shifted : acc_q[op_s1.dest] + shifted;
	assign q_next  = psum_q + QW'(prd_q);

	always_comb begin
		var_eff    = dfull ? acc_q[ACC_VAR] : '0;
		beyond     = acc_q[ACC_DK] > var_eff;
		profitable = !tick_q.spread[31] && (mn != 32'd0)
			&& (ACC_W'({mn, 16'd0}) > acc_q[ACC_RHS])
			&& !(ACC_W'(lsum_q) < acc_q[ACC_LIQ]);
		tpos = tv_q && (((acc_q[ACC_TA] > acc_q[ACC_TB]) && (tick_q.price > first_q))
			|| ((acc_q[ACC_TA] < acc_q[ACC_TB]) && (tick_q.price < first_q)));
		tneg = tv_q && (((acc_q[ACC_TA] > acc_q[ACC_TB]) && (tick_q.price < first_q))
			|| ((acc_q[ACC_TA] < acc_q[ACC_TB]) && (tick_q.price > first_q)));
		size = (acc_q[ACC_SIZE][63:16] > 48'(mp_q)) ? mp_q : acc_q[ACC_SIZE][47:16];
	end

	assign load = (state_q == ST_DEC) && (!sig_valid_q || !sig_stall);

	always_ff @(posedge clk) begin
		if (state_q == ST_UPD) begin
			price_mem[pn_next] <= tick_q.price;
			diff_mem[dw_q]     <= tick_q.spread;
		end
		prd_q <= price_mem[rp_q];
		drd_q <= diff_mem[dw_q];
	end

	always_ff @(posedge clk) begin
		prod_s1 <= 64'(op.a) * 64'(op.b);
		op_s1   <= op;
		if (tick_valid && !tick_stall) begin
			tick_q <= tick_data;
		end
		if (load) begin
			if (profitable && beyond && !tick_q.spread[31] && tpos) begin
				sig_q <= '{ACT_BUY, size, tick_q.price};
			end else if (profitable && beyond && tick_q.spread[31] && tneg) begin
				sig_q <= '{ACT_SELL, size, tick_q.price};
			end else begin
				sig_q <= '{ACT_HOLD, 32'd0, 32'd0};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tc_q <= '0;
			fl_q <= '0;
			sf_q <= '0;
			ml_q <= '0;
			rm_q <= 32'd65536;
			mp_q <= '0;
			tp_q <= 7'd20;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_TRANSACTION_COST:  tc_q <= cfg_data;
				REG_FILL_LATENCY:      fl_q <= cfg_data;
				REG_SLIPPAGE_FACTOR:   sf_q <= cfg_data;
				REG_MINIMUM_LIQUIDITY: ml_q <= cfg_data;
				REG_RISK_MULTIPLIER:   rm_q <= cfg_data;
				REG_MAX_POSITION:      mp_q <= cfg_data;
				REG_TREND_PERIOD:      tp_q <= cfg_data[6:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			pn_q        <= '0;
			rp_q        <= '0;
			dw_q        <= '0;
			pfill_q     <= '0;
			dfill_q     <= '0;
			lfill_q     <= '0;
			lsum_q      <= '0;
			dsum_q      <= '0;
			mo_q        <= '0;
			sx_q        <= '0;
			tv_q        <= 1'b0;
			psum_q      <= '0;
			wsum_q      <= '0;
			first_q     <= '0;
			mv_s1       <= 1'b0;
			sig_valid_q <= 1'b0;
			for (int i = 0; i < ACC_N; i++) begin
				acc_q[i] <= '0;
			end
			for (int i = 0; i < LIQ_WINDOW; i++) begin
				liq_q[i] <= '0;
			end
		end else begin
			mv_s1 <= (state_q == ST_MUL) && (cnt_q < 7'(NOPS));
			if (mv_s1) begin
				acc_q[op_s1.dest] <= acc_sum;
			end
			if (load) begin
				sig_valid_q <= 1'b1;
			end else if (!sig_stall) begin
				sig_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (tick_valid) begin
						state_q <= ST_UPD;
					end
				end
				ST_UPD: begin
					pn_q   <= pn_next;
					rp_q   <= pn_next;
					dw_q   <= (dw_q == DAW'(DEV_WINDOW - 1)) ? '0 : dw_q + 1'b1;
					if (dfull) begin
						mo_q   <= drd_q[31] ? (~drd_q + 32'd1) : drd_q;
						dsum_q <= dsum_q + d_ext - SW'($signed(drd_q));
					end else begin
						mo_q    <= 32'd0;
						dsum_q  <= dsum_q + d_ext;
						dfill_q <= dfill_q + 1'b1;
					end
					if (pfill_q != PFW'(PRICE_WINDOW_MAX)) begin
						pfill_q <= pfill_q + 1'b1;
					end
					liq_q[0] <= tick_q.liquidity_sample;
					for (int i = 1; i < LIQ_WINDOW; i++) begin
						liq_q[i] <= liq_q[i-1];
					end
					if (lfill_q == LFW'(LIQ_WINDOW)) begin
						lsum_q <= lsum_q + LW'(tick_q.liquidity_sample)
							- LW'(liq_q[LIQ_WINDOW-1]);
					end else begin
						lsum_q  <= lsum_q + LW'(tick_q.liquidity_sample);
						lfill_q <= lfill_q + 1'b1;
					end
					sx_q   <= 13'((14'(tp_q) * 14'(tp_q - 7'd1)) >> 1);
					psum_q <= '0;
					wsum_q <= '0;
					for (int i = 0; i < ACC_N; i++) begin
						if (4'(i) != ACC_SQS) begin
							acc_q[i] <= '0;
						end
					end
					cnt_q <= '0;
					if ((tp_q >= 7'd2) && (CW'(tp_q) <= CW'(pfill_q)
						|| (CW'(tp_q) == CW'(pfill_q) + CW'(1)
						&& pfill_q != PFW'(PRICE_WINDOW_MAX)))) begin
						tv_q    <= 1'b1;
						state_q <= ST_TRD;
					end else begin
						tv_q    <= 1'b0;
						state_q <= ST_MUL;
					end
				end
				ST_TRD: begin
					rp_q <= (rp_q == '0) ? PAW'(PRICE_WINDOW_MAX - 1) : rp_q - 1'b1;
					if (cnt_q != '0) begin
						psum_q <= q_next;
					end
					if (cnt_q == tp_q) begin
						first_q <= prd_q;
						cnt_q   <= '0;
						state_q <= ST_MUL;
					end else begin
						cnt_q <= cnt_q + 1'b1;
						if (cnt_q != '0) begin
							wsum_q <= wsum_q + WW'(q_next);
						end
					end
				end
				ST_MUL: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == 7'(NOPS)) begin
						state_q <= ST_DEC;
					end
				end
				ST_DEC: begin
					if (load) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	a_load_from_dec: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(sig_valid_q) |-> $past(state_q) == ST_DEC)
		else $error("result register loaded outside the decision step");

	a_hold_zero: assert property (@(posedge clk) disable iff (!arst_n)
		sig_valid_q && sig_q.action == ACT_HOLD |-> sig_q.trade_size == 32'd0
		&& sig_q.trade_price == 32'd0)
		else $error("hold result carries a size or a price");

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		pfill_q <= PFW'(PRICE_WINDOW_MAX) && dfill_q <= DW'(DEV_WINDOW)
		&& lfill_q <= LFW'(LIQ_WINDOW))
		else $error("window fill count overran its window");

	a_mul_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_MUL |-> cnt_q <= 7'(NOPS))
		else $error("multiply sequence ran past its last step");

	a_trend_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_TRD |-> cnt_q <= tp_q && tv_q)
		else $error("slope fit ran past the trend period");

endmodule

### tb/tb_arbitrage_signal_generator.sv
// Testbench for the arbitrage signal generator: predicted trade signals checked against the block.
`timescale 1ns / 100ps

class signal_scoreboard;
	logic [31:0] tx_cost, fill_lat, slip, min_liq, risk_mult, max_pos;
	logic [6:0] trend_len;
	logic [31:0] prices[64];
	logic [31:0] diffs[30];
	logic [31:0] liqs[5];
	int price_cnt, diff_cnt, liq_cnt;
	asg_pkg::signal_t pending[$];
	int mismatches;

	function new();
		tx_cost = 0; fill_lat = 0; slip = 0; min_liq = 0;
		risk_mult = 32'd65536; max_pos = 0; trend_len = 7'd20;
		price_cnt = 0; diff_cnt = 0; liq_cnt = 0; mismatches = 0;
		foreach (prices[i]) prices[i] = 0;
		foreach (diffs[i]) diffs[i] = 0;
		foreach (liqs[i]) liqs[i] = 0;
	endfunction

	function void set_reg(logic [2:0] idx, logic [31:0] val);
		case (idx)
			asg_pkg::REG_TRANSACTION_COST: tx_cost = val;
			asg_pkg::REG_FILL_LATENCY: fill_lat = val;
			asg_pkg::REG_SLIPPAGE_FACTOR: slip = val;
			asg_pkg::REG_MINIMUM_LIQUIDITY: min_liq = val;
			asg_pkg::REG_RISK_MULTIPLIER: risk_mult = val;
			asg_pkg::REG_MAX_POSITION: max_pos = val;
			asg_pkg::REG_TREND_PERIOD: trend_len = val[6:0];
			default: ;
		endcase
	endfunction

	function void note_tick(asg_pkg::tick_t t);
		asg_pkg::signal_t r;
		logic signed [63:0] d, s_sum;
		logic [63:0] dmag, smag;
		logic [127:0] sq_sum, var_w, lhs_w, rhs_w, size;
		logic [63:0] liq_sum, psum, wsum, a, b, tl;
		bit profitable, beyond;
		int trend, slope, n;
		for (int i = 63; i > 0; i--) prices[i] = prices[i-1];
		prices[0] = t.price;
		if (price_cnt < 64) price_cnt++;
		for (int i = 29; i > 0; i--) diffs[i] = diffs[i-1];
		diffs[0] = t.spread;
		if (diff_cnt < 30) diff_cnt++;
		for (int i = 4; i > 0; i--) liqs[i] = liqs[i-1];
		liqs[0] = t.liquidity_sample;
		if (liq_cnt < 5) liq_cnt++;
		d = 64'(t.spread);
		dmag = d < 0 ? 64'(-d) : 64'(d);
		var_w = 0;
		if (diff_cnt >= 30) begin
			s_sum = 0; sq_sum = 0;
			for (int k = 0; k < 30; k++) begin
				s_sum += 64'(signed'(diffs[k]));
				sq_sum += 128'(64'(signed'(diffs[k])) * 64'(signed'(diffs[k])));
			end
			smag = s_sum < 0 ? 64'(-s_sum) : 64'(s_sum);
			var_w = sq_sum * 30 - 128'(smag) * 128'(smag);
		end
		beyond = (128'(dmag) * 128'(dmag) * 128'(9000000)) > var_w;
		profitable = 0;
		if (d > 0) begin
			lhs_w = 128'(dmag) << 16;
			rhs_w = (128'(tx_cost) << 16) + 128'(fill_lat) * 128'(slip);
			profitable = lhs_w > rhs_w;
		end
		n = liq_cnt;
		liq_sum = 0;
		for (int k = 0; k < n; k++) liq_sum += 64'(liqs[k]);
		if (liq_sum < 64'(min_liq) * n) profitable = 0;
		trend = 0;
		if (trend_len >= 2 && trend_len <= price_cnt) begin
			tl = 64'(trend_len);
			psum = 0; wsum = 0; slope = 0;
			for (int k = 0; k < trend_len; k++) begin
				psum += 64'(prices[trend_len-1-k]);
				wsum += 64'(k) * prices[trend_len-1-k];
			end
			a = tl * wsum;
			b = (tl * (tl - 1) / 2) * psum;
			if (a > b) slope = 1; else if (a < b) slope = -1;
			if (prices[0] > prices[trend_len-1]) trend = slope;
			else if (prices[0] < prices[trend_len-1]) trend = -slope;
		end
		r = '0;
		r.action = asg_pkg::ACT_HOLD;
		if (profitable && beyond && ((d > 0 && trend > 0) || (d < 0 && trend < 0))) begin
			size = (128'(dmag) * 128'(risk_mult)) >> 16;
			if (size > 128'(max_pos)) size = 128'(max_pos);
			r.action = d > 0 ? asg_pkg::ACT_BUY : asg_pkg::ACT_SELL;
			r.trade_size = size[31:0];
			r.trade_price = t.price;
		end
		pending.push_back(r);
	endfunction

	function void check_signal(asg_pkg::signal_t got);
		asg_pkg::signal_t want;
		if (pending.size() == 0) begin
			mismatches++;
			if (mismatches <= 10) $display("Unexpected signal %p", got);
			return;
		end
		want = pending.pop_front();
		if (got.action !== want.action || got.trade_size !== want.trade_size ||
				got.trade_price !== want.trade_price) begin
			mismatches++;
			if (mismatches <= 10) $display("Signal mismatch: expected %p, got %p", want, got);
		end
	endfunction
endclass

module tb_arbitrage_signal_generator;
	import asg_pkg::*;

	logic clk = 0;
	logic arst_n = 0;
	logic tick_valid = 0;
	logic tick_stall;
	tick_t tick_data = '0;
	logic sig_valid;
	logic sig_stall = 0;
	signal_t sig_data;
	logic cfg_valid = 0;
	logic cfg_ready;
	logic [2:0] cfg_index = '0;
	logic [31:0] cfg_data = '0;

	signal_scoreboard board;
	int send_idle, recv_stall;
	logic [31:0] last_price;

	always #4 clk = ~clk;

	arbitrage_signal_generator dut (.*);

	always @(posedge clk) begin
		if (arst_n) begin
			if (sig_valid && !sig_stall) board.check_signal(sig_data);
			sig_stall <= ($urandom_range(99) < recv_stall);
		end
	end

	task automatic write_reg(logic [2:0] idx, logic [31:0] val);
		cfg_valid <= 1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		board.set_reg(idx, val);
		cfg_valid <= 0;
		@(posedge clk);
	endtask

	task automatic send_tick(logic [31:0] p, logic [31:0] dif, logic [31:0] liq);
		tick_t t;
		while ($urandom_range(99) < send_idle) @(posedge clk);
		t.price = p;
		t.spread = dif;
		t.liquidity_sample = liq;
		tick_valid <= 1;
		tick_data <= t;
		do @(posedge clk); while (tick_stall);
		board.note_tick(t);
		tick_valid <= 0;
		@(posedge clk);
	endtask

	task automatic drain();
		while (board.pending.size() != 0) @(posedge clk);
		repeat (200) @(posedge clk);
	endtask

	task automatic random_ticks(int count, int mode);
		logic [31:0] p, dif;
		for (int i = 0; i < count; i++) begin
			if (mode == 0 || $urandom_range(9) == 0) begin
				p = $urandom();
				dif = $urandom();
			end else begin
				p = last_price + (mode == 1 ? $urandom_range(4096) : -$urandom_range(4096));
				dif = $urandom_range(1 << 20);
				if ($urandom_range(3) == 0) dif = -dif;
			end
			last_price = p;
			send_tick(p, dif, $urandom_range(3) == 0 ? $urandom() : $urandom_range(1000));
		end
	endtask

	initial begin
		board = new();
		last_price = 32'h0100_0000;
		send_idle = 0; recv_stall = 0;
		repeat (10) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		send_tick(32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
		send_tick(32'h0, 32'h8000_0000, 32'h0);
		send_tick(32'h5, 32'h0, 32'h1);
		for (int i = 0; i < 22; i++)
			send_tick(32'h1000 + i * 32'h100, 32'h40 + i, 32'h10);
		drain();
		write_reg(REG_MAX_POSITION, 32'hFFFF_FFFF);
		write_reg(REG_TREND_PERIOD, 32'd2);
		random_ticks(150, 1);
		drain();
		send_idle = 70;
		write_reg(REG_TRANSACTION_COST, 32'h0000_0100);
		write_reg(REG_FILL_LATENCY, 32'h0001_0000);
		write_reg(REG_SLIPPAGE_FACTOR, 32'h0000_0800);
		write_reg(REG_MINIMUM_LIQUIDITY, 32'd200);
		write_reg(REG_RISK_MULTIPLIER, 32'h0002_8000);
		write_reg(REG_MAX_POSITION, 32'h0010_0000);
		write_reg(REG_TREND_PERIOD, 32'd64);
		random_ticks(250, 1);
		drain();
		send_idle = 0; recv_stall = 70;
		write_reg(REG_TREND_PERIOD, 32'd10);
		write_reg(REG_RISK_MULTIPLIER, 32'hFFFF_FFFF);
		write_reg(REG_MINIMUM_LIQUIDITY, 32'd0);
		random_ticks(250, 2);
		drain();
		send_idle = 30; recv_stall = 30;
		write_reg(REG_TREND_PERIOD, 32'd0);
		random_ticks(40, 0);
		drain();
		write_reg(REG_TREND_PERIOD, 32'd127);
		write_reg(REG_TRANSACTION_COST, 32'hFFFF_FFFF);
		write_reg(REG_FILL_LATENCY, 32'hFFFF_FFFF);
		write_reg(REG_SLIPPAGE_FACTOR, 32'hFFFF_FFFF);
		write_reg(REG_MINIMUM_LIQUIDITY, 32'hFFFF_FFFF);
		random_ticks(40, 0);
		drain();
		write_reg(REG_TREND_PERIOD, 32'd3);
		write_reg(REG_TRANSACTION_COST, 32'd0);
		write_reg(REG_FILL_LATENCY, 32'd0);
		write_reg(REG_SLIPPAGE_FACTOR, 32'd0);
		write_reg(REG_MINIMUM_LIQUIDITY, 32'd50);
		write_reg(REG_RISK_MULTIPLIER, 32'h0000_8000);
		write_reg(REG_MAX_POSITION, 32'h0000_0000);
		random_ticks(150, 1);
		drain();
		write_reg(REG_MAX_POSITION, 32'h0800_0000);
		random_ticks(150, 0);
		send_idle = 0; recv_stall = 0;
		random_ticks(150, 1);
		drain();
		if (board.mismatches == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

	initial begin
		#20ms;
		$display("== FAIL ==");
		$finish;
	end
endmodule

### arbitrage_signal_generator.f
rtl/asg_pkg.sv
rtl/arbitrage_signal_generator.sv
tb/tb_arbitrage_signal_generator.sv
